[sv/assert_macros.svh]
// Assertion macros shared by the search table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sols_pkg.sv]
// Shared types, codes and constants of the self-organizing search table.
package sols_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int WORD_W       = 32;
    localparam int CMD_W        = 2;
    localparam int MODE_W       = 2;
    localparam int STS_W        = 2;
    localparam int HIT_W        = 5;

    // Command codes of an input word
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Reorder modes
    localparam logic [MODE_W-1:0] MODE_NONE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRANSPOSE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FRONT     = 2'd2;

    // Result status codes
    localparam logic [STS_W-1:0] STS_OK   = 2'd0;
    localparam logic [STS_W-1:0] STS_MISS = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_RESULT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic do_append;
        logic do_full;
        logic do_clear;
        logic do_none;
        logic scan;
        logic swap_a;
        logic swap_b;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             full;
        logic             hit;
        logic             miss;
        logic             swap_req;
        logic             out_busy;
    } t_dp_sts;

endpackage

[sv/sols_ifs.sv]
// Valid/ready channel interfaces for items, results and configuration.
interface sols_item_if import sols_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [WORD_W-1:0] search_key;
    logic signed [WORD_W-1:0] entry_value;

    modport source (output valid, command, search_key, entry_value, input ready);
    modport sink   (input valid, command, search_key, entry_value, output ready);
endinterface

interface sols_result_if import sols_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [STS_W-1:0] status;
    logic [HIT_W-1:0] hit_index;

    modport source (output valid, status, hit_index, input ready);
    modport sink   (input valid, status, hit_index, output ready);
endinterface

interface sols_cfg_if import sols_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] reorder_mode;

    modport source (output valid, reorder_mode, input ready);
    modport sink   (input valid, reorder_mode, output ready);
endinterface

[sv/self_organizing_linear_search_unit.sv]
// Top level of the self-organizing linear search table.
// Append, clear or other command: decode, then the result state, which loads the output register.
// Search: decode, scan to a hit or a miss, the two swap writes when a swap is needed, then the result state.
// Throughput: one item at a time, bounded by the one-entry-per-cycle memory scan.
// A finished result waits in an output register; the next item's result waits until it is taken.
// Reset (synchronous, active low) empties the table and sets reorder mode to none.
module self_organizing_linear_search_unit import sols_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sols_item_if.sink     i_item,
    sols_cfg_if.sink      i_cfg,
    sols_result_if.source o_result
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_item_ready;

    // Item ready comes from the controller
    assign i_item.ready = w_item_ready;

    sols_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (w_item_ready),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    sols_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cfg    (i_cfg),
        .o_result (o_result),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts)
    );

endmodule

[sv/sols_datapath.sv]
// Datapath: entry memory, scan pointer, compare, swap writes and result register.
`include "assert_macros.svh"

module sols_datapath import sols_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sols_item_if.sink           i_item,
    sols_cfg_if.sink            i_cfg,
    sols_result_if.source       o_result,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [WORD_W-1:0] mem [CAPACITY];

    logic [CMD_W-1:0]  r_cmd;
    logic [WORD_W-1:0] r_key;
    logic [WORD_W-1:0] r_value;
    logic [CW-1:0]     r_count;
    logic [MODE_W-1:0] r_mode;
    logic [CW-1:0]     r_ptr;
    logic              r_cmp_vld;
    logic [IW-1:0]     r_cmp_idx;
    logic [WORD_W-1:0] r_rd_data;
    logic [WORD_W-1:0] r_prev_data;
    logic [WORD_W-1:0] r_front_data;
    logic [WORD_W-1:0] r_partner_data;
    logic [IW-1:0]     r_partner_idx;
    logic [IW-1:0]     r_hit_idx;
    logic [STS_W-1:0]  r_status;
    logic              r_out_vld;
    logic [STS_W-1:0]  r_out_status;
    logic [HIT_W-1:0]  r_out_hit;

    logic              rd_en;
    logic              match;
    logic              mode_swaps;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [IW+HIT_W-1:0] hit_ext;

    // Read the next entry while the scan has entries left
    assign rd_en      = i_cmd.scan && (r_ptr < r_count);
    assign match      = r_cmp_vld && (r_rd_data == r_key);
    assign mode_swaps = (r_mode == MODE_TRANSPOSE) || (r_mode == MODE_FRONT);
    assign hit_ext    = {{HIT_W{1'b0}}, r_hit_idx};

    // Status toward the controller
    assign o_sts.command  = r_cmd;
    assign o_sts.full     = (r_count >= CAP_C);
    assign o_sts.hit      = match;
    assign o_sts.miss     = !r_cmp_vld && (r_ptr >= r_count);
    assign o_sts.swap_req = match && (r_cmp_idx != '0) && mode_swaps;
    assign o_sts.out_busy = r_out_vld && !o_result.ready;

    // Configuration is always taken
    assign i_cfg.ready = 1'b1;

    // Select the single write port source
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_hit_idx;
        wr_data = r_partner_data;
        if (i_cmd.do_append) begin
            wr_en   = 1'b1;
            wr_addr = r_count[IW-1:0];
            wr_data = r_value;
        end else if (i_cmd.swap_a) begin
            wr_en   = 1'b1;
            wr_addr = r_hit_idx;
            wr_data = r_partner_data;
        end else if (i_cmd.swap_b) begin
            wr_en   = 1'b1;
            wr_addr = r_partner_idx;
            wr_data = r_key;
        end
    end

    // Entry memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_ptr[IW-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_mode    <= MODE_NONE;
            r_ptr     <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_mode <= i_cfg.reorder_mode;
            end
            if (i_cmd.do_clear) begin
                r_count <= '0;
            end else if (i_cmd.do_append) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.load_item) begin
                r_ptr     <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= rd_en;
                if (rd_en) begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd   <= i_item.command;
            r_key   <= i_item.search_key;
            r_value <= i_item.entry_value;
        end
        if (rd_en) begin
            r_cmp_idx <= r_ptr[IW-1:0];
        end
        // Keep the predecessor and the front entry for a later swap
        if (i_cmd.scan && r_cmp_vld) begin
            r_prev_data <= r_rd_data;
            if (r_cmp_idx == '0) begin
                r_front_data <= r_rd_data;
            end
        end
        if (i_cmd.scan && match) begin
            r_status  <= STS_OK;
            r_hit_idx <= r_cmp_idx;
            if (r_mode == MODE_TRANSPOSE) begin
                r_partner_idx  <= r_cmp_idx - 1'b1;
                r_partner_data <= r_prev_data;
            end else begin
                r_partner_idx  <= '0;
                r_partner_data <= r_front_data;
            end
        end else if (i_cmd.scan && o_sts.miss) begin
            r_status  <= STS_MISS;
            r_hit_idx <= '0;
        end else if (i_cmd.do_full) begin
            r_status  <= STS_FULL;
            r_hit_idx <= '0;
        end else if (i_cmd.do_append || i_cmd.do_clear || i_cmd.do_none) begin
            r_status  <= STS_OK;
            r_hit_idx <= '0;
        end
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            r_out_hit    <= hit_ext[HIT_W-1:0];
        end
    end

    assign o_result.valid     = r_out_vld;
    assign o_result.status    = r_out_status;
    assign o_result.hit_index = r_out_hit;

    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CAP_C, "entry count above capacity")
    `ASSERT_IMPL(a_port_clash, i_clk, i_rst_n, wr_en, !rd_en, "memory read and write in one cycle")
    `ASSERT_IMPL(a_swap_in_use, i_clk, i_rst_n, i_cmd.swap_a || i_cmd.swap_b, {1'b0, wr_addr} < {1'b0, r_count}, "swap writes outside used entries")

endmodule

[sv/sols_ctrl.sv]
// Controller: sequences decode, scan, swap writes and result hand-off.
`include "assert_macros.svh"

module sols_ctrl import sols_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    output logic    o_item_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_item_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_item_ready    = 1'b1;
                o_cmd.load_item = i_item_valid;
                if (i_item_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_RESULT;
                case (i_sts.command)
                    CMD_SEARCH: begin
                        n_state = ST_SCAN;
                    end
                    CMD_APPEND: begin
                        if (i_sts.full) begin
                            o_cmd.do_full = 1'b1;
                        end else begin
                            o_cmd.do_append = 1'b1;
                        end
                    end
                    CMD_CLEAR: begin
                        o_cmd.do_clear = 1'b1;
                    end
                    default: begin
                        o_cmd.do_none = 1'b1;
                    end
                endcase
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    n_state = i_sts.swap_req ? ST_SWAP_A : ST_RESULT;
                end else if (i_sts.miss) begin
                    n_state = ST_RESULT;
                end
            end
            ST_SWAP_A: begin
                o_cmd.swap_a = 1'b1;
                n_state      = ST_SWAP_B;
            end
            ST_SWAP_B: begin
                o_cmd.swap_b = 1'b1;
                n_state      = ST_RESULT;
            end
            ST_RESULT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_scan_ends, i_clk, i_rst_n, (r_state == ST_SCAN) && i_sts.hit, r_state != ST_SCAN, "scan kept running after a hit")

endmodule

[tb/sv/self_organizing_linear_search_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench: directed table plus random sessions, scored against a local table model.
module self_organizing_linear_search_unit_tb;
    import sols_pkg::*;

    localparam int CLK_HALF_NS   = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int MAX_IDLE      = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_AFTER    = 300;     // replies taken before the long hold-off
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 40;
    localparam longint TIMEOUT_NS = 64'd20_000_000;

    localparam int NO_WRITE = -1;
    localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [HIT_W-1:0] hit_index;
    } t_reply;

    typedef struct {
        int                mode_write;
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] value;
        bit                typed;
        t_reply            want;
    } t_dir_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sols_item_if   item_bus ();
    sols_cfg_if    cfg_bus ();
    sols_result_if result_bus ();

    self_organizing_linear_search_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .i_cfg    (cfg_bus),
        .o_result (result_bus)
    );

    // Local copy of the table state
    logic [WORD_W-1:0] table_words [DEF_CAPACITY];
    int                table_count = 0;
    logic [MODE_W-1:0] table_mode  = MODE_NONE;

    t_reply   pending_replies [$];
    t_dir_row dir_rows [$];

    int n_errors      = 0;
    int n_useful      = 0;
    int n_replies     = 0;
    int n_mode_writes = 0;
    int n_hits        = 0;
    int n_misses      = 0;
    int n_full        = 0;
    bit burst         = 1'b0;

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // Advance the table state by one command word and return the reply it produces
    function automatic t_reply apply_command(input logic [CMD_W-1:0] cmd,
                                             input logic [WORD_W-1:0] key,
                                             input logic [WORD_W-1:0] value);
        t_reply            r;
        int                hit;
        int                partner;
        logic [WORD_W-1:0] tmp;
        r.status    = STS_OK;
        r.hit_index = '0;
        hit         = -1;
        case (cmd)
            CMD_SEARCH: begin
                for (int i = 0; i < table_count; i++) begin
                    if (hit < 0 && table_words[i] == key) hit = i;
                end
                if (hit < 0) begin
                    r.status = STS_MISS;
                    n_misses++;
                end else begin
                    r.hit_index = hit[HIT_W-1:0];
                    n_hits++;
                    // a hit at the front never moves
                    if (hit != 0 && (table_mode == MODE_TRANSPOSE || table_mode == MODE_FRONT))
                    begin
                        partner = (table_mode == MODE_TRANSPOSE) ? hit - 1 : 0;
                        tmp = table_words[hit];
                        table_words[hit] = table_words[partner];
                        table_words[partner] = tmp;
                    end
                end
            end
            CMD_APPEND: begin
                if (table_count >= DEF_CAPACITY) begin
                    r.status = STS_FULL;
                    n_full++;
                end else begin
                    table_words[table_count] = value;
                    table_count++;
                end
            end
            CMD_CLEAR: begin
                table_count = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_row(input int mode_write, input logic [CMD_W-1:0] cmd,
                           input logic [WORD_W-1:0] key, input logic [WORD_W-1:0] value,
                           input bit typed, input logic [STS_W-1:0] status,
                           input logic [HIT_W-1:0] hit_index);
        t_dir_row row;
        row.mode_write     = mode_write;
        row.cmd            = cmd;
        row.key            = key;
        row.value          = value;
        row.typed          = typed;
        row.want.status    = status;
        row.want.hit_index = hit_index;
        dir_rows.push_back(row);
    endtask

    // Offer one word after a random gap (none in burst); record its reply at the accepting edge
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] key,
                             input logic [WORD_W-1:0] value, input bit typed,
                             input t_reply want);
        t_reply predicted;
        int     gap;
        gap = burst ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid       <= 1'b1;
        item_bus.command     <= cmd;
        item_bus.search_key  <= key;
        item_bus.entry_value <= value;
        @(posedge i_clk);
        while (item_bus.ready !== 1'b1) @(posedge i_clk);
        predicted = apply_command(cmd, key, value);
        pending_replies.push_back(typed ? want : predicted);
        if (cmd != CMD_UNUSED) n_useful++;
    endtask

    // Drop the input, wait for the block to go idle, then write the reorder mode
    task automatic write_mode(input logic [MODE_W-1:0] mode);
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_bus.valid        <= 1'b1;
        cfg_bus.reorder_mode <= mode;
        @(posedge i_clk);
        while (cfg_bus.ready !== 1'b1) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        table_mode = mode;
        n_mode_writes++;
    endtask

    // One session: new mode, usually a clear, a fill, then searches with some noise
    task automatic run_random_phase();
        logic [WORD_W-1:0] stored [$];
        logic [WORD_W-1:0] pool [4];
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] value;
        logic [CMD_W-1:0]  cmd;
        logic [MODE_W-1:0] mode;
        int                n_fill;
        int                n_search;
        int                r;
        t_reply            none;
        none = '0;
        mode = MODE_W'($urandom_range(0, 3));
        write_mode(mode);
        burst = ($urandom_range(0, 3) == 0);
        foreach (pool[i]) pool[i] = $urandom;
        if ($urandom_range(0, 9) != 0) send_item(CMD_CLEAR, $urandom, $urandom, 1'b0, none);

        // mostly short fills, some that run past full
        r = $urandom_range(0, 9);
        if (r < 2) n_fill = DEF_CAPACITY + $urandom_range(1, 3);
        else if (r == 2) n_fill = 0;
        else n_fill = $urandom_range(1, 12);
        for (int i = 0; i < n_fill; i++) begin
            value = $urandom_range(0, 1) ? pool[$urandom_range(0, 3)] : $urandom;
            send_item(CMD_APPEND, $urandom, value, 1'b0, none);
            stored.push_back(value);
        end

        n_search = $urandom_range(4, 24);
        for (int i = 0; i < n_search; i++) begin
            r     = $urandom_range(0, 19);
            cmd   = CMD_SEARCH;
            value = $urandom;
            if (r == 0) begin
                cmd = CMD_W'($urandom_range(0, 3));
                key = $urandom;
            end else if (r < 4 || stored.size() == 0) begin
                key = $urandom;
            end else begin
                key = stored[$urandom_range(0, stored.size() - 1)];
            end
            send_item(cmd, key, value, 1'b0, none);
        end
    endtask

    initial begin : stimulus
        t_dir_row row;
        int       wait_cnt;
        item_bus.valid       = 1'b0;
        item_bus.command     = CMD_SEARCH;
        item_bus.search_key  = '0;
        item_bus.entry_value = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.reorder_mode = MODE_NONE;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: mode writes ride on the row they precede
        add_row(int'(MODE_NONE), CMD_SEARCH, '0, '0, 1'b1, STS_MISS, 5'd0);   // empty table
        add_row(NO_WRITE, CMD_APPEND, '0, WORD_MIN, 1'b1, STS_OK, 5'd0);
        add_row(NO_WRITE, CMD_APPEND, '0, WORD_MAX, 1'b1, STS_OK, 5'd0);
        add_row(NO_WRITE, CMD_APPEND, ALL_ONES, '0, 1'b1, STS_OK, 5'd0);
        add_row(NO_WRITE, CMD_APPEND, '0, ALL_ONES, 1'b1, STS_OK, 5'd0);
        add_row(NO_WRITE, CMD_APPEND, '0, WORD_MAX, 1'b1, STS_OK, 5'd0);
        add_row(NO_WRITE, CMD_SEARCH, WORD_MIN, ALL_ONES, 1'b1, STS_OK, 5'd0);
        add_row(NO_WRITE, CMD_SEARCH, ALL_ONES, '0, 1'b1, STS_OK, 5'd3);
        add_row(NO_WRITE, CMD_SEARCH, WORD_MAX, '0, 1'b1, STS_OK, 5'd1);  // first of two
        add_row(NO_WRITE, CMD_SEARCH, 32'h0000_0007, '0, 1'b1, STS_MISS, 5'd0);
        add_row(NO_WRITE, CMD_UNUSED, ALL_ONES, ALL_ONES, 1'b1, STS_OK, 5'd0);
        add_row(int'(MODE_TRANSPOSE), CMD_SEARCH, ALL_ONES, '0, 1'b1, STS_OK, 5'd3);
        add_row(NO_WRITE, CMD_SEARCH, ALL_ONES, '0, 1'b0, STS_OK, 5'd0);
        add_row(NO_WRITE, CMD_SEARCH, WORD_MIN, '0, 1'b1, STS_OK, 5'd0);  // front hit
        add_row(int'(MODE_FRONT), CMD_SEARCH, '0, '0, 1'b0, STS_OK, 5'd0);
        add_row(NO_WRITE, CMD_SEARCH, '0, '0, 1'b0, STS_OK, 5'd0);
        add_row(NO_WRITE, CMD_SEARCH, WORD_MIN, '0, 1'b0, STS_OK, 5'd0);
        add_row(NO_WRITE, CMD_APPEND, '0, 32'h5555_5555, 1'b0, STS_OK, 5'd0);
        add_row(int'(MODE_UNUSED), CMD_SEARCH, WORD_MAX, '0, 1'b0, STS_OK, 5'd0);
        add_row(NO_WRITE, CMD_SEARCH, WORD_MAX, '0, 1'b0, STS_OK, 5'd0);
        add_row(NO_WRITE, CMD_CLEAR, ALL_ONES, ALL_ONES, 1'b1, STS_OK, 5'd0);
        add_row(NO_WRITE, CMD_SEARCH, WORD_MIN, '0, 1'b1, STS_MISS, 5'd0);
        add_row(NO_WRITE, CMD_APPEND, '0, 32'hAAAA_AAAA, 1'b1, STS_OK, 5'd0);
        add_row(NO_WRITE, CMD_SEARCH, 32'hAAAA_AAAA, '0, 1'b1, STS_OK, 5'd0);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.mode_write != NO_WRITE) write_mode(row.mode_write[MODE_W-1:0]);
            send_item(row.cmd, row.key, row.value, row.typed, row.want);
        end

        while (n_useful < dir_rows.size() + RANDOM_ITEMS) run_random_phase();
        item_bus.valid <= 1'b0;

        // Drain the outstanding replies
        wait_cnt = 0;
        while (pending_replies.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        if (pending_replies.size() != 0) begin
            $display("self_organizing_linear_search_unit_tb: done, errors");
            $finish;
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            $display("covered %0d words, %0d replies, %0d mode writes",
                     n_useful, n_replies, n_mode_writes);
            $display("search hits %0d, misses %0d, full-table appends %0d",
                     n_hits, n_misses, n_full);
            if (n_errors == 0) begin
                $display("self_organizing_linear_search_unit_tb: done, clean");
            end else begin
                $display("self_organizing_linear_search_unit_tb: done, errors");
            end
            $finish;
        end
    end

    // Take replies with random stalls, one long hold-off, and score each one
    initial begin : reply_sink
        t_reply want;
        int     stall;
        bit     held;
        bit     steady;
        held             = 1'b0;
        steady           = 1'b0;
        result_bus.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!held && n_replies == HOLD_AFTER) begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end else begin
                stall = steady ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if ($urandom_range(0, 39) == 0) steady = !steady;
            if (stall > 0) begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (result_bus.valid !== 1'b1) @(posedge i_clk);
            n_replies++;
            if (pending_replies.size() == 0) begin
                $error("unexpected reply: status %0d hit_index %0d",
                       result_bus.status, result_bus.hit_index);
                n_errors++;
            end else begin
                want = pending_replies.pop_front();
                if (result_bus.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, result_bus.status);
                    n_errors++;
                end
                if (result_bus.hit_index !== want.hit_index) begin
                    $error("hit_index: expected %0d, got %0d",
                           want.hit_index, result_bus.hit_index);
                    n_errors++;
                end
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("self_organizing_linear_search_unit_tb: done, errors");
        $finish;
    end

endmodule
